// ===== design/lphs_pkg.sv =====
// Shared constants, types and the modulo digit step of the linear-probe hash set.
package lphs_pkg;

	// Table geometry.
	localparam int TABLE_SIZE = 251;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);

	// Word fields.
	localparam int ACT_W      = 2;
	localparam int KEY_W      = 31;
	localparam int STATUS_W   = 2;
	localparam int OUT_SLOT_W = 8;
	localparam int MARK_W     = 2;

	// Home slot reduction: the key is consumed one digit per cycle, most significant first.
	localparam int DIGIT_W    = 8;
	localparam int KEY_PAD_W  = ((KEY_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int DIGITS     = KEY_PAD_W / DIGIT_W;
	localparam int STEP_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Request codes.
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

	// Result codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// Slot marks.
	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	// A classified request as it travels from front to back.
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] home;
	} req_t;

	// Folds one digit into a running remainder modulo TABLE_SIZE, one bit at a time.
	function automatic logic [SLOT_W-1:0] mod_digit(input logic [SLOT_W-1:0] rem,
		input logic [DIGIT_W-1:0] digit);
		logic [SLOT_W:0]   t;
		logic [SLOT_W-1:0] r;
		r = rem;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {r, digit[i]};
			if (t >= (SLOT_W + 1)'(TABLE_SIZE)) begin
				t = t - (SLOT_W + 1)'(TABLE_SIZE);
			end
			r = t[SLOT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/lphs_front.sv =====
// Front end: accepts request words and works out the home slot of each key.
module lphs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [lphs_pkg::ACT_W-1:0]  action,
	input  logic [lphs_pkg::KEY_W-1:0]  key,
	output logic                        full,
	output logic                        q_push,
	output lphs_pkg::req_t              q_req,
	input  logic                        q_full
);
	import lphs_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_HAND} front_state_t;

	front_state_t            state_q;
	logic [ACT_W-1:0]        act_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_PAD_W-1:0]    shift_q;
	logic [SLOT_W-1:0]       rem_q;
	logic [STEP_CNT_W-1:0]   step_q;

	// One word is held at a time; the next is taken once this one is handed on.
	assign full   = (state_q != F_IDLE);
	assign q_push = (state_q == F_HAND) && !q_full;
	assign q_req  = '{action: act_q, key: key_q, home: rem_q};

	// Sequencer: capture, reduce the key one digit per cycle, then hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			act_q   <= '0;
			key_q   <= '0;
			shift_q <= '0;
			rem_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						act_q   <= action;
						key_q   <= key;
						shift_q <= KEY_PAD_W'(key);
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= F_REDUCE;
					end
				end
				F_REDUCE: begin
					rem_q   <= mod_digit(rem_q, shift_q[KEY_PAD_W-1 -: DIGIT_W]);
					shift_q <= shift_q << DIGIT_W;
					step_q  <= step_q + 1'b1;
					if (step_q == STEP_CNT_W'(DIGITS - 1)) begin
						state_q <= F_HAND;
					end
				end
				F_HAND: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/lphs_queue.sv =====
// Short first-in first-out queue of classified requests between front and back.
module lphs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  lphs_pkg::req_t wr_req,
	output logic           full,
	input  logic           rd_en,
	output lphs_pkg::req_t rd_req,
	output logic           empty
);
	import lphs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_req = entry_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_req;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/lphs_back.sv =====
// Back end: probes the slot table one slot per cycle and holds the result word.
module lphs_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  lphs_pkg::req_t                  q_req,
	output logic                            q_pop,
	output logic                            clearing,
	output logic                            res_empty,
	input  logic                            res_pop,
	output logic [lphs_pkg::STATUS_W-1:0]   status,
	output logic [lphs_pkg::OUT_SLOT_W-1:0] slot_index
);
	import lphs_pkg::*;

	localparam int ENTRY_W = MARK_W + KEY_W;

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_RESULT} back_state_t;

	// Slot table: mark above key in each entry.
	logic [ENTRY_W-1:0]    table_mem [TABLE_SIZE];
	logic [ENTRY_W-1:0]    rd_q;
	logic [SLOT_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]    wr_data;

	back_state_t           state_q;
	logic [SLOT_W-1:0]     clr_q;
	req_t                  req_q;
	logic [SLOT_W-1:0]     s_q;
	logic [SLOT_W-1:0]     n_q;
	logic [STATUS_W-1:0]   st_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  res_valid_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [OUT_SLOT_W-1:0] res_slot_q;

	logic [SLOT_W-1:0]     s_next;
	logic [MARK_W-1:0]     mark;
	logic [KEY_W-1:0]      stored_key;
	logic                  last_probe;
	logic                  finish;
	logic [STATUS_W-1:0]   fin_status;
	logic                  res_take;
	logic                  res_load;

	assign clearing   = (state_q == B_CLEAR);
	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign res_empty  = !res_valid_q;
	assign status     = res_status_q;
	assign slot_index = res_slot_q;
	assign res_take   = res_pop && res_valid_q;
	assign res_load   = (state_q == B_RESULT) && (!res_valid_q || res_take);

	// Next slot with wrap, and the read address: home slot on load, else the next slot.
	assign s_next     = (s_q == SLOT_W'(TABLE_SIZE - 1)) ? '0 : s_q + 1'b1;
	assign rd_addr    = (state_q == B_IDLE) ? q_req.home : s_next;
	assign mark       = rd_q[ENTRY_W-1 -: MARK_W];
	assign stored_key = rd_q[KEY_W-1:0];
	assign last_probe = (n_q == SLOT_W'(TABLE_SIZE - 1));

	// Table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_q <= table_mem[rd_addr];
	end

	// Clearing write, or probe decision on the slot just read and the write it causes.
	always_comb begin
		finish     = 1'b0;
		fin_status = ST_MISSING;
		wr_en      = 1'b0;
		wr_addr    = s_q;
		wr_data    = {MARK_USED, req_q.key};
		if (state_q == B_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = {MARK_EMPTY, KEY_W'(0)};
		end else if (state_q == B_PROBE) begin
			if (req_q.action == ACT_INSERT) begin
				if (mark != MARK_USED) begin
					wr_en      = 1'b1;
					finish     = 1'b1;
					fin_status = ST_OK;
				end else if (last_probe) begin
					finish     = 1'b1;
					fin_status = ST_FULL;
				end
			end else begin
				if (mark == MARK_EMPTY) begin
					finish = 1'b1;
				end else if (mark == MARK_USED && stored_key == req_q.key) begin
					finish     = 1'b1;
					fin_status = ST_OK;
					if (req_q.action == ACT_ERASE) begin
						wr_en   = 1'b1;
						wr_data = {MARK_DELETED, stored_key};
					end
				end else if (last_probe) begin
					finish = 1'b1;
				end
			end
		end
	end

	// Sequencer: clearing pass, load, probe loop, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			req_q        <= '0;
			s_q          <= '0;
			n_q          <= '0;
			st_q         <= ST_MISSING;
			slot_q       <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_MISSING;
			res_slot_q   <= '0;
		end else begin
			// The result register refills in the cycle its word is taken.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(TABLE_SIZE - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						req_q <= q_req;
						s_q   <= q_req.home;
						n_q   <= '0;
						case (q_req.action) inside
							ACT_INSERT, ACT_FIND, ACT_ERASE: begin
								state_q <= B_PROBE;
							end
							default: begin
								st_q    <= ST_MISSING;
								slot_q  <= '0;
								state_q <= B_RESULT;
							end
						endcase
					end
				end
				B_PROBE: begin
					if (finish) begin
						st_q    <= fin_status;
						slot_q  <= s_q;
						state_q <= B_RESULT;
					end else begin
						s_q <= s_next;
						n_q <= n_q + 1'b1;
					end
				end
				B_RESULT: begin
					if (res_load) begin
						res_status_q <= st_q;
						res_slot_q   <= (st_q == ST_OK) ? OUT_SLOT_W'(slot_q) : '0;
						state_q      <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/linear_probe_hash_set_top.sv =====
// Open-addressing hash set of 31-bit keys with linear probing and deleted-slot marks.
//
// Request words enter through push/full: a word is taken at a clock edge with push high
// and full low, and carries action (insert, find, erase) and key. Result words leave
// through empty/pop: while empty is low, status and slot_index show the oldest result,
// which is taken at an edge with pop high. Every request word yields one result word,
// in order.
// The front end reduces the key modulo the table size one byte per cycle and takes a
// new word only once the last one is handed to the queue, which a full queue holds
// back. The back end loads each request, probes slots in turn from its home slot and
// then loads the result register; the slot table memory, read once per cycle, sets
// the probe rate. A probe goes at most once around the full circle of the table.
// After reset the back end sweeps the table once, one slot per cycle, marking every
// slot empty; full stays high for that time. If the receiver does not pop, one result
// waits in the output register, the back end holds its next result, and the queue and
// front end fill; full then stays high until pop resumes.
module linear_probe_hash_set_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [lphs_pkg::ACT_W-1:0]      action,
	input  logic [lphs_pkg::KEY_W-1:0]      key,
	output logic                            empty,
	input  logic                            pop,
	output logic [lphs_pkg::STATUS_W-1:0]   status,
	output logic [lphs_pkg::OUT_SLOT_W-1:0] slot_index
);
	import lphs_pkg::*;

	logic front_full;
	logic clearing;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t front_req;
	req_t back_req;

	// No request word is taken until the clearing pass is over.
	assign full = front_full || clearing;

	// Front end: key reduction.
	lphs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !clearing),
		.action (action),
		.key    (key),
		.full   (front_full),
		.q_push (q_push),
		.q_req  (front_req),
		.q_full (q_full)
	);

	// Queue between front and back.
	lphs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_req (front_req),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_req (back_req),
		.empty  (q_empty)
	);

	// Back end: probe engine and result register.
	lphs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_req      (back_req),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.res_empty  (empty),
		.res_pop    (pop),
		.status     (status),
		.slot_index (slot_index)
	);

	// A result that is not a success carries slot zero.
	a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (slot_index == '0))
		else $error("non-zero slot index with a failing status");

	// Nothing reaches the queue while the table is being cleared.
	a_queue_empty_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> q_empty)
		else $error("queued request during clearing pass");

	// The front end never pushes into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	// No result word appears before the clearing pass is over.
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> empty)
		else $error("result word during clearing pass");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the linear-probe hash set: directed, random and full-table words.
`timescale 1ns / 1ps

module testbench;
	import lphs_pkg::*;

	// Unused request code; the block must answer it with "not found" and leave the table alone.
	localparam logic [ACT_W-1:0] ACT_UNDEFINED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX       = {KEY_W{1'b1}};
	localparam int               WATCHDOG_LIMIT = 3000;
	localparam int               TAIL_CYCLES    = 300;
	localparam int               RANDOM_WORDS   = 650;
	// Largest multiplier that keeps home + TABLE_SIZE * m inside the key range.
	localparam int unsigned      KEY_MULT_MAX   = int'(KEY_MAX) / TABLE_SIZE - 1;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [OUT_SLOT_W-1:0] slot;
	} result_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [ACT_W-1:0]      action = ACT_FIND;
	logic [KEY_W-1:0]      key = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [OUT_SLOT_W-1:0] slot_index;

	// Shadow copy of the table, the words still owed by the block, and run bookkeeping.
	logic [KEY_W-1:0]  shadow_key [TABLE_SIZE];
	logic [MARK_W-1:0] shadow_mark [TABLE_SIZE];
	int                shadow_used = 0;
	result_word_t      pending_results [$];
	int                error_count = 0;
	bit                quiet = 1'b0;
	int                pop_stall = 0;
	int                idle_cycles = 0;

	linear_probe_hash_set_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.key        (key),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.slot_index (slot_index)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one request to the shadow table and returns the word the block should produce.
	function automatic result_word_t probe_table(input logic [ACT_W-1:0] act,
		input logic [KEY_W-1:0] k);
		result_word_t res;
		int unsigned  s;
		int           n;
		bit           done;
		res.status = ST_MISSING;
		res.slot   = '0;
		s          = k % TABLE_SIZE;
		done       = 1'b0;
		if (act == ACT_INSERT) begin
			res.status = ST_FULL;
			for (n = 0; n < TABLE_SIZE && !done; n++) begin
				if (shadow_mark[s] != MARK_USED) begin
					shadow_key[s]  = k;
					shadow_mark[s] = MARK_USED;
					shadow_used++;
					res.status = ST_OK;
					res.slot   = OUT_SLOT_W'(s);
					done       = 1'b1;
				end else begin
					s = (s + 1 == TABLE_SIZE) ? 0 : s + 1;
				end
			end
		end else if (act == ACT_FIND || act == ACT_ERASE) begin
			// Deleted slots are stepped over; an empty slot ends the search.
			for (n = 0; n < TABLE_SIZE && !done; n++) begin
				if (shadow_mark[s] == MARK_EMPTY) begin
					done = 1'b1;
				end else if (shadow_mark[s] == MARK_USED && shadow_key[s] == k) begin
					res.status = ST_OK;
					res.slot   = OUT_SLOT_W'(s);
					if (act == ACT_ERASE) begin
						shadow_mark[s] = MARK_DELETED;
						shadow_used--;
					end
					done = 1'b1;
				end else begin
					s = (s + 1 == TABLE_SIZE) ? 0 : s + 1;
				end
			end
		end
		return res;
	endfunction

	// Picks a key that is currently stored, starting the scan at a random slot.
	function automatic bit pick_stored_key(output logic [KEY_W-1:0] k);
		int unsigned s;
		int          n;
		bit          hit;
		s   = $urandom_range(0, TABLE_SIZE - 1);
		hit = 1'b0;
		k   = '0;
		for (n = 0; n < TABLE_SIZE && !hit; n++) begin
			if (shadow_mark[s] == MARK_USED) begin
				k   = shadow_key[s];
				hit = 1'b1;
			end else begin
				s = (s + 1 == TABLE_SIZE) ? 0 : s + 1;
			end
		end
		return hit;
	endfunction

	// Keys mostly land in two narrow home ranges, one at the wrap point, so chains form.
	function automatic logic [KEY_W-1:0] clustered_key();
		int unsigned h;
		case ($urandom_range(0, 3))
			0: begin
				return KEY_W'($urandom);
			end
			1: begin
				h = $urandom_range(TABLE_SIZE - 11, TABLE_SIZE - 1);
			end
			default: begin
				h = $urandom_range(0, 20);
			end
		endcase
		return KEY_W'(h + TABLE_SIZE * $urandom_range(0, KEY_MULT_MAX));
	endfunction

	// Presents one request word, waits for it to be taken, and records the word it owes.
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k);
		push   <= 1'b1;
		action <= act;
		key    <= k;
		do
			@(posedge clk);
		while (full);
		pending_results.push_back(probe_table(act, k));
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Holds the sender back until every owed word has come out.
	task automatic drain;
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Extreme keys, hits, misses, a repeated erase and the unused request code.
	task automatic test_single_keys;
		send_word(ACT_INSERT, '0);
		send_word(ACT_INSERT, KEY_MAX);
		send_word(ACT_FIND, '0);
		send_word(ACT_FIND, KEY_MAX);
		send_word(ACT_FIND, KEY_W'(1));
		send_word(ACT_ERASE, '0);
		send_word(ACT_FIND, '0);
		send_word(ACT_ERASE, '0);
		send_word(ACT_UNDEFINED, KEY_MAX);
		send_word(ACT_FIND, KEY_MAX);
	endtask

	// A chain across the end of the table that reuses and skips deleted slots.
	task automatic test_collision_chain;
		logic [KEY_W-1:0] base;
		base = KEY_W'(TABLE_SIZE - 1);
		send_word(ACT_INSERT, base);
		send_word(ACT_INSERT, base + KEY_W'(TABLE_SIZE));
		send_word(ACT_INSERT, base + KEY_W'(2 * TABLE_SIZE));
		send_word(ACT_INSERT, base + KEY_W'(3 * TABLE_SIZE));
		send_word(ACT_FIND, base + KEY_W'(3 * TABLE_SIZE));
		send_word(ACT_ERASE, base + KEY_W'(TABLE_SIZE));
		send_word(ACT_FIND, base + KEY_W'(2 * TABLE_SIZE));
		send_word(ACT_FIND, base + KEY_W'(TABLE_SIZE));
		send_word(ACT_INSERT, base + KEY_W'(2 * TABLE_SIZE));
		send_word(ACT_ERASE, base + KEY_W'(2 * TABLE_SIZE));
		send_word(ACT_FIND, base + KEY_W'(2 * TABLE_SIZE));
		drain();
	endtask

	// Random mix of requests; finds and erases often aim at keys that are stored.
	task automatic test_random_traffic;
		logic [KEY_W-1:0] k;
		int               roll;
		repeat (RANDOM_WORDS) begin
			roll = $urandom_range(0, 99);
			k    = clustered_key();
			if (roll < 35) begin
				if ($urandom_range(0, 6) == 0) void'(pick_stored_key(k));
				send_word(ACT_INSERT, k);
			end else if (roll < 95) begin
				if ($urandom_range(0, 4) < 3 && !pick_stored_key(k)) k = clustered_key();
				send_word((roll < 65) ? ACT_FIND : ACT_ERASE, k);
			end else begin
				send_word(ACT_UNDEFINED, KEY_W'($urandom));
			end
		end
	endtask

	// Fills the table, then probes full circles through used and deleted slots.
	task automatic test_full_table;
		logic [KEY_W-1:0] k;
		quiet = 1'b1;
		while (shadow_used < TABLE_SIZE) send_word(ACT_INSERT, clustered_key());
		repeat (3) send_word(ACT_INSERT, clustered_key());
		repeat (3) send_word(ACT_FIND, KEY_W'($urandom));
		repeat (20) begin
			void'(pick_stored_key(k));
			send_word(ACT_FIND, k);
			send_word(ACT_ERASE, k);
			send_word(ACT_FIND, k);
		end
		repeat (4) send_word(ACT_INSERT, KEY_W'($urandom));
		drain();
	endtask

	// Result side: checks each word taken and drives pop with random stall bursts.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual status %0d slot %0d",
					$time, status, slot_index);
				error_count++;
			end else begin
				if (status !== pending_results[0].status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, pending_results[0].status, status);
					error_count++;
				end
				if (slot_index !== pending_results[0].slot) begin
					$display("%0t: slot_index mismatch, expected %0d, actual %0d",
						$time, pending_results[0].slot, slot_index);
					error_count++;
				end
				void'(pending_results.pop_front());
			end
		end
		if (pop_stall > 0) begin
			pop       <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			pop       <= 1'b0;
			pop_stall <= $urandom_range(0, 17);
		end else begin
			pop <= 1'b1;
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		foreach (shadow_mark[i]) begin
			shadow_mark[i] = MARK_EMPTY;
			shadow_key[i]  = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_keys();
		test_collision_chain();
		test_random_traffic();
		test_full_table();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
